// ----- rtl/bole_pkg.sv -----
package bole_pkg;

   // request codes
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_INSERT     = 3'd4;
   localparam logic [2:0] OP_REMOVE     = 3'd5;
   localparam logic [2:0] OP_SEARCH     = 3'd6;

   // result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] item_value;
      logic [7:0]         insert_position;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [8:0] element_count;
   } rsp_item_type;

   // what every cell does on the apply edge
   typedef enum logic [1:0] {
      MODE_HOLD       = 2'd0,
      MODE_INSERT     = 2'd1,
      MODE_SHIFT_LEFT = 2'd2
   } mode_type;

   // broadcast to the whole row of cells
   typedef struct packed {
      logic        sample;
      mode_type    mode;
      logic [31:0] value;
      logic [31:0] key;
   } cell_cmd_type;

endpackage

// ----- rtl/bole_cell.sv -----
module bole_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 9
) (
   input  logic                  clock,
   input  bole_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]         count,
   input  logic [CW-1:0]         insert_pos,
   input  logic                  shift_left,
   input  logic [31:0]           left_data,
   input  logic [31:0]           right_data,
   output logic [31:0]           data,
   output logic                  match
);
   import bole_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [31:0] data_ff;
   logic        match_ff;

   always_ff @(posedge clock) begin
      case (cmd.mode)
         MODE_INSERT: begin
            if (IDX == insert_pos) begin
               data_ff <= cmd.value;
            end else if (IDX > insert_pos) begin
               data_ff <= left_data;
            end
         end
         MODE_SHIFT_LEFT: begin
            if (shift_left) begin
               data_ff <= right_data;
            end
         end
         default: begin
            data_ff <= data_ff;
         end
      endcase
   end

   // only occupied entries may match
   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         match_ff <= (IDX < count) && (data_ff == cmd.key);
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ----- rtl/bole_prefix.sv -----
module bole_prefix #(
   parameter int N = 256
) (
   input  logic [N-1:0] flags,
   output logic [N-1:0] prefix
);
   localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

   logic [N-1:0] stage [LEVELS+1];

   assign stage[0] = flags;

   // log-depth prefix or: bit i is set when any flag at or below i is set
   for (genvar lvl = 0; lvl < LEVELS; lvl++) begin : g_level
      for (genvar i = 0; i < N; i++) begin : g_bit
         if (i >= (1 << lvl)) begin : g_merge
            assign stage[lvl+1][i] = stage[lvl][i] | stage[lvl][i - (1 << lvl)];
         end else begin : g_pass
            assign stage[lvl+1][i] = stage[lvl][i];
         end
      end
   end

   assign prefix = stage[LEVELS];

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_data: req_type, item_value, insert_position
// rsp_      out        rsp_valid/rsp_stall  rsp_data: status, found, element_count
//
// each item is accepted, then applied: the accept edge samples each cell's compare
// against item_value, the apply edge does the shift and loads the result register;
// the per-cell compare and the prefix-or tree over CAPACITY cells set the clock period
// reset is synchronous and clears the count and the control; cell data is not cleared
// a result stalled on rsp_ holds the apply step, and req_stall stays high meanwhile
// the next item can be accepted while a finished result still waits on rsp_
module bounded_ordered_list_engine #(
   parameter int CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bole_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bole_pkg::rsp_item_type rsp_data
);
   import bole_pkg::*;

   // count width holds CAPACITY itself
   localparam int CW = $clog2(CAPACITY + 1);
   // width that holds both the count and an 8-bit position
   localparam int PW = (CW > 8) ? CW : 8;
   // width that holds both the count and the 9-bit result field
   localparam int XW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   req_item_type hold_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic         accept;
   logic         apply;
   cell_cmd_type cmd;
   logic [CW-1:0] insert_pos;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] count_ext;
   logic [XW-1:0] count_wide;

   logic [31:0]       cell_data  [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] prefix_in;
   logic [CAPACITY-1:0] shift_vec;
   logic              any_match;
   logic              is_full;
   logic              is_empty;

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   // apply only when the result register is free or being emptied
   assign apply     = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);

   assign is_full  = (count_ff == CAP_COUNT);
   assign is_empty = (count_ff == '0);

   // pop front shifts every cell; remove shifts from the first match upward
   assign prefix_in = (hold_ff.req_type == OP_POP_FRONT) ?
                      CAPACITY'(1) : match_vec;
   assign any_match = shift_vec[CAPACITY-1];

   // insert slot, clamped to the count
   assign pos_ext   = PW'(hold_ff.insert_position);
   assign count_ext = PW'(count_ff);

   always_comb begin
      case (hold_ff.req_type)
         OP_PUSH_BACK:  insert_pos = count_ff;
         OP_PUSH_FRONT: insert_pos = '0;
         default: begin
            if (pos_ext > count_ext) begin
               insert_pos = count_ff;
            end else begin
               insert_pos = pos_ext[CW-1:0];
            end
         end
      endcase
   end

   // command broadcast and the result
   always_comb begin
      cmd.sample   = accept;
      cmd.key      = req_data.item_value;
      cmd.value    = hold_ff.item_value;
      cmd.mode     = MODE_HOLD;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (apply) begin
         rsp_in.status = ST_DONE;
         rsp_in.found  = 1'b0;
         case (hold_ff.req_type)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
               if (is_full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  cmd.mode = MODE_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  cmd.mode = MODE_SHIFT_LEFT;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_REMOVE: begin
               if (any_match) begin
                  cmd.mode = MODE_SHIFT_LEFT;
                  count_in = count_ff - 1'b1;
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            OP_SEARCH: begin
               rsp_in.found = any_match;
            end
            default: begin
               rsp_in.status = ST_DONE;
            end
         endcase
         count_wide           = XW'(count_in);
         rsp_in.element_count = count_wide[8:0];
         rsp_valid_in         = 1'b1;
      end else begin
         count_wide = XW'(count_ff);
      end
   end

   // sequencer
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            state_in = accept ? S_APPLY : S_IDLE;
         end
         S_APPLY: begin
            state_in = apply ? S_IDLE : S_APPLY;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // first-match mask for the left shift
   bole_prefix #(
      .N (CAPACITY)
   ) u_prefix (
      .flags  (prefix_in),
      .prefix (shift_vec)
   );

   // row of cells, each takes from its left or right neighbour
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] left_data;
      logic [31:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      bole_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .insert_pos (insert_pos),
         .shift_left (shift_vec[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (match_vec[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- tb/bole_list_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the list and checks every result
module bole_list_checker #(
   parameter int CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  bole_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bole_pkg::rsp_item_type rsp_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     results_checked,
   output int                     peak_len,
   output int                     full_refusals,
   output int                     empty_pops
);
   import bole_pkg::*;

   logic [31:0]  list_mem [CAPACITY];
   int unsigned  list_len;
   rsp_item_type due_results[$];
   int           mismatches;
   int           checked;
   int           peak;
   int           refusals;
   int           empties;

   function automatic logic [1:0] place_value(input int unsigned where, input logic [31:0] v);
      int unsigned at;
      int unsigned i;
      if (list_len >= CAPACITY) return ST_FULL;
      at = (where > list_len) ? list_len : where;
      for (i = list_len; i > at; i--) list_mem[i] = list_mem[i - 1];
      list_mem[at] = v;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic int find_first(input logic [31:0] v);
      int i;
      for (i = 0; i < int'(list_len); i++)
         if (list_mem[i] == v) return i;
      return -1;
   endfunction

   function automatic void drop_at(input int unsigned at);
      int unsigned i;
      for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
      list_len--;
   endfunction

   function automatic rsp_item_type apply_request(input req_item_type r);
      rsp_item_type res;
      int           hit;
      res = '0;
      res.status = ST_DONE;
      case (r.req_type)
         OP_PUSH_BACK:  res.status = place_value(list_len, r.item_value);
         OP_PUSH_FRONT: res.status = place_value(0, r.item_value);
         OP_INSERT:     res.status = place_value(r.insert_position, r.item_value);
         OP_POP_BACK, OP_POP_FRONT: begin
            if (list_len == 0) res.status = ST_EMPTY;
            else if (r.req_type == OP_POP_FRONT) drop_at(0);
            else list_len--;
         end
         OP_REMOVE: begin
            hit = find_first(r.item_value);
            if (hit < 0) res.status = ST_NOT_FOUND;
            else drop_at(hit);
         end
         OP_SEARCH: res.found = (find_first(r.item_value) >= 0);
         default: ;
      endcase
      res.element_count = 9'(list_len);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         list_len = 0;
         due_results.delete();
      end else begin
         // results first: the item accepted at this edge cannot have answered yet
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d found %0d count %0d",
                           rsp_data.status, rsp_data.found, rsp_data.element_count);
            end else begin
               // oldest expectation sits at the head
               want = due_results[0];
               due_results.delete(0);
               checked++;
               if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                   rsp_data.element_count !== want.element_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d: expected status %0d found %0d count %0d, ",
                               "got status %0d found %0d count %0d"}, checked,
                              want.status, want.found, want.element_count,
                              rsp_data.status, rsp_data.found, rsp_data.element_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_request(req_data);
            due_results.insert(due_results.size(), want);
            if (want.status == ST_FULL) refusals++;
            if (want.status == ST_EMPTY) empties++;
            if (int'(list_len) > peak) peak = list_len;
         end
      end
      fail_count      <= mismatches;
      pending_count   <= due_results.size();
      results_checked <= checked;
      peak_len        <= peak;
      full_refusals   <= refusals;
      empty_pops      <= empties;
   end

endmodule

// ----- tb/bounded_ordered_list_engine_tb.sv -----
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;
   import bole_pkg::*;

   localparam int         CAPACITY      = 256;
   localparam int         RANDOM_ITEMS  = 928;
   localparam int         PACE_BLOCK    = 60;   // items per idling phase
   localparam int         SETTLE_CYCLES = 8;
   localparam logic [2:0] OP_UNUSED     = 3'd7; // the one code the block ignores

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   int fail_count;
   int pending_count;
   int results_checked;
   int peak_len;
   int full_refusals;
   int empty_pops;

   // idling knobs, percent of cycles
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int sent            = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_ordered_list_engine #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   bole_list_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .peak_len        (peak_len),
      .full_refusals   (full_refusals),
      .empty_pops      (empty_pops)
   );

   // receiver side: stall drawn fresh every cycle, may drop or rise under a waiting result
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic req_item_type req_of(input logic [2:0] op, input logic [31:0] v,
                                           input logic [7:0] at);
      req_item_type r;
      r.req_type        = op;
      r.item_value      = v;
      r.insert_position = at;
      return r;
   endfunction

   // called at a rising edge; returns at the edge that accepts the item, with valid
   // still high so a back-to-back item needs no lowering
   task automatic send_req(input req_item_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   initial begin : stimulus
      req_item_type item;
      int           n;
      int           add_pct;
      int           roll;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      // empty list: both pops report empty, remove finds nothing, search misses
      send_req(req_of(OP_POP_BACK,   32'd0, 8'd0));
      send_req(req_of(OP_POP_FRONT,  32'd0, 8'd0));
      send_req(req_of(OP_REMOVE,     32'd0, 8'd0));
      send_req(req_of(OP_SEARCH,     32'd0, 8'd0));
      send_req(req_of(OP_UNUSED,     32'hffff_ffff, 8'hff));
      // build [0, min, 5, max, -1] through every way of adding
      send_req(req_of(OP_PUSH_BACK,  32'h7fff_ffff, 8'd0));
      send_req(req_of(OP_PUSH_FRONT, 32'h8000_0000, 8'd0));
      send_req(req_of(OP_INSERT,     32'd0, 8'd0));          // insert at zero
      send_req(req_of(OP_INSERT,     32'hffff_ffff, 8'hff)); // insert past end
      send_req(req_of(OP_INSERT,     32'd5, 8'd2));          // insert in the middle
      send_req(req_of(OP_SEARCH,     32'h8000_0000, 8'd0));
      send_req(req_of(OP_SEARCH,     32'd12345, 8'd0));
      send_req(req_of(OP_REMOVE,     32'hffff_ffff, 8'd0));  // remove the tail
      send_req(req_of(OP_REMOVE,     32'd999, 8'd0));        // remove without match
      // duplicate value: remove takes only the first
      send_req(req_of(OP_PUSH_BACK,  32'd5, 8'd0));
      send_req(req_of(OP_REMOVE,     32'd5, 8'd0));
      send_req(req_of(OP_INSERT,     32'h5555_5555, 8'haa));
      send_req(req_of(OP_INSERT,     32'haaaa_aaaa, 8'h55));
      send_req(req_of(OP_UNUSED,     32'd5, 8'd1));
      send_req(req_of(OP_POP_BACK,   32'd0, 8'd0));
      send_req(req_of(OP_POP_FRONT,  32'd0, 8'd0));
      send_req(req_of(OP_SEARCH,     32'd5, 8'd0));

      // random part
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // idling phases rotate so gaps land on every step of the block's work
         case ((n / PACE_BLOCK) % 4)
            0: begin
               sender_idle_pct = 0;
               stall_pct      <= 0;
            end
            1: begin
               sender_idle_pct = 87;
               stall_pct      <= 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct      <= 87;
            end
            default: begin
               sender_idle_pct = 11;
               stall_pct      <= 11;
            end
         endcase

         // request mix drifts: fill to capacity and beat on the full list,
         // drain down to empty, then churn around the middle
         add_pct = (n < 320) ? 93 : (n < 750) ? 4 : 45;
         roll    = $urandom_range(0, 99);
         if (roll < add_pct) begin
            case ($urandom_range(0, 2))
               0:       item.req_type = OP_PUSH_BACK;
               1:       item.req_type = OP_PUSH_FRONT;
               default: item.req_type = OP_INSERT;
            endcase
         end else if (roll < 98) begin
            case ($urandom_range(0, 5))
               0, 1:    item.req_type = OP_POP_BACK;
               2, 3:    item.req_type = OP_POP_FRONT;
               4:       item.req_type = OP_REMOVE;
               default: item.req_type = OP_SEARCH;
            endcase
         end else begin
            item.req_type = OP_UNUSED;
         end

         // half the values from a small pool so removes and searches find matches
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: item.item_value = 32'($urandom_range(0, 15)) - 32'd8;
            9:             item.item_value = $urandom_range(0, 1) ? 32'h7fff_ffff
                                                                  : 32'h8000_0000;
            default:       item.item_value = $urandom();
         endcase

         // half the positions inside a short list, the other half over the whole range
         item.insert_position = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 7));
         send_req(item);
      end

      req_valid <= 1'b0;
      stall_pct <= 0;

      // one edge first so the last item's expectation is visible, then drain
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d requests, checked %0d results; list peaked at %0d of %0d entries",
               sent, results_checked, peak_len, CAPACITY);
      $display("%0d adds refused on a full list, %0d pops on an empty list",
               full_refusals, empty_pops);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
